[hdl/multi_rate_history_averager_assert.svh]
// Assertion helpers, clocked on clk_i with reset rst_ni.
`ifndef MULTI_RATE_HISTORY_AVERAGER_ASSERT_SVH
`define MULTI_RATE_HISTORY_AVERAGER_ASSERT_SVH

// Same-cycle implication.
`define MRHA_ASSERT_IMM(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mrha: same-cycle check failed");

// Next-cycle implication.
`define MRHA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mrha: next-cycle check failed");

`endif

[hdl/mrha_pkg.sv]
`default_nettype none

package mrha_pkg;

  localparam int unsigned RING_DEPTH = 128;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned PTR_WP     = PTR_W + 1;

  localparam int unsigned MIN_SPAN = 60;
  localparam int unsigned QTR_SPAN = 15;
  localparam int unsigned MIN_CNT  = (MIN_SPAN < RING_DEPTH - 1) ? MIN_SPAN : RING_DEPTH - 1;
  localparam int unsigned QTR_CNT  = (QTR_SPAN < RING_DEPTH - 1) ? QTR_SPAN : RING_DEPTH - 1;

  localparam int unsigned CNT_W  = $clog2(MIN_CNT + 1);
  localparam int unsigned SUM_W  = 16 + $clog2(MIN_CNT);

  // Reciprocal divide: floor(x / n) == (x * ceil(2^RECIP_SH / n)) >> RECIP_SH
  // for every window sum x, since n * 2^SUM_W <= 2^RECIP_SH.
  localparam int unsigned     RECIP_SH  = SUM_W + CNT_W;
  localparam int unsigned     REC_W     = RECIP_SH;
  localparam int unsigned     PROD_W    = SUM_W + REC_W;
  localparam longint unsigned MIN_RECIP = ((64'd1 << RECIP_SH) + MIN_CNT - 1) / MIN_CNT;
  localparam longint unsigned QTR_RECIP = ((64'd1 << RECIP_SH) + QTR_CNT - 1) / QTR_CNT;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned LVL_W  = 2;
  localparam int unsigned AGE_W  = 7;
  localparam int unsigned OFF_W  = AGE_W + 1;
  localparam int unsigned KIND_W = 2;

  localparam int unsigned IN_DATA_W  = ((SMP_W + LVL_W + AGE_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((SMP_W + 7) / 8) * 8;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH = 2'd0,
    ACT_MIN  = 2'd1,
    ACT_QTR  = 2'd2,
    ACT_READ = 2'd3
  } act_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ = 2'd0,
    KIND_MIN  = 2'd1,
    KIND_QTR  = 2'd2
  } kind_e;

  typedef enum logic [LVL_W-1:0] {
    LVL_SEC = 2'd0,
    LVL_MIN = 2'd1,
    LVL_QTR = 2'd2
  } lvl_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_SINIT,
    S_SUM,
    S_DRAIN,
    S_DIVI,
    S_WRITE,
    S_MOD,
    S_RADDR,
    S_RISSUE,
    S_RDATA,
    S_OUT
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic push;
    logic sum_init;
    logic sum_step;
    logic rd_en;
    logic div_init;
    logic avg_wr;
    logic off_sub;
    logic raddr;
    logic res_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic off_big;
    logic out_free;
  } sts_t;

  // Slot 'off' entries behind p; off must be below RING_DEPTH.
  function automatic ptr_t ring_back(ptr_t p, ptr_t off);
    logic [PTR_W:0] wide;
    if (p >= off) begin
      wide = {1'b0, p} - {1'b0, off};
    end else begin
      wide = {1'b0, p} + PTR_WP'(RING_DEPTH) - {1'b0, off};
    end
    return wide[PTR_W-1:0];
  endfunction

  function automatic ptr_t ring_next(ptr_t p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

[hdl/multi_rate_history_averager.sv]
// Multi-rate history averager: seconds, minutes and quarter-hour rings.
// Input stream (s_axis): tuser = action, tdata = sample, level, age.
//   push stores a sample; minute tick averages the newest 60 seconds entries
//   into the minutes ring; quarter tick averages the newest 15 minute
//   entries into the quarter ring; read returns one ring entry by age.
// Output stream (m_axis): tuser = kind, tdata = value. Ticks and reads
//   give one transfer each, push gives none.
// One item is worked at a time. Ticks read the window one ring entry per
//   cycle from the memory port, then divide by a registered multiply by the
//   reciprocal of the window length. The next input transfer can follow in
//   the cycle after a push stores its sample or another item's result is
//   loaded.
// A result sits in the output register until taken; the next item is
//   accepted meanwhile, and its own result waits for that register.
// Reset clears the pointers and fill flags; slots never written read zero,
//   so no clearing pass runs and input is taken right after reset.
`default_nettype none

module multi_rate_history_averager (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mrha_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // sample, level, age, zero pad
  input  logic [mrha_pkg::ACT_W-1:0]         s_axis_tuser,  // action
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mrha_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // value
  output logic [mrha_pkg::KIND_W-1:0]        m_axis_tuser   // kind
);
  import mrha_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [SMP_W-1:0]  out_value;

  // field unpack, lowest bits first
  logic [SMP_W-1:0]  in_sample;
  logic [LVL_W-1:0]  in_level;
  logic [AGE_W-1:0]  in_age;

  assign in_sample = s_axis_tdata[SMP_W-1:0];
  assign in_level  = s_axis_tdata[SMP_W+LVL_W-1:SMP_W];
  assign in_age    = s_axis_tdata[SMP_W+LVL_W+AGE_W-1:SMP_W+LVL_W];

  mrha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_act_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mrha_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_act_i    (s_axis_tuser),
    .in_sample_i (in_sample),
    .in_level_i  (in_level),
    .in_age_i    (in_age),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_value_o (out_value)
  );

  assign m_axis_tdata = OUT_DATA_W'(out_value);

endmodule

`default_nettype wire

[hdl/mrha_datapath.sv]
`default_nettype none

module mrha_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mrha_pkg::cmd_t                   cmd_i,
  output mrha_pkg::sts_t                   sts_o,
  input  logic [mrha_pkg::ACT_W-1:0]       in_act_i,
  input  logic [mrha_pkg::SMP_W-1:0]       in_sample_i,
  input  logic [mrha_pkg::LVL_W-1:0]       in_level_i,
  input  logic [mrha_pkg::AGE_W-1:0]       in_age_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [mrha_pkg::KIND_W-1:0]      out_kind_o,
  output logic [mrha_pkg::SMP_W-1:0]       out_value_o
);
  import mrha_pkg::*;

  typedef enum logic [1:0] {RSEL_SEC, RSEL_MIN, RSEL_QTR, RSEL_NONE} rsel_e;

  // item
  act_e               act_q;
  logic [SMP_W-1:0]   smp_q;
  logic [LVL_W-1:0]   lvl_q;
  logic [OFF_W-1:0]   off_q;

  // ring state
  logic [SMP_W-1:0]   sec_mem [RING_DEPTH];
  logic [SMP_W-1:0]   min_mem [RING_DEPTH];
  logic [SMP_W-1:0]   qtr_mem [RING_DEPTH];
  ptr_t               sec_ptr_q, min_ptr_q, qtr_ptr_q;
  logic               sec_wrap_q, min_wrap_q, qtr_wrap_q;

  // walk / read
  ptr_t               addr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               rd_vld_q;
  logic               rd_ok_q;
  logic [SMP_W-1:0]   rd_sec_q, rd_min_q, rd_qtr_q;
  logic [SMP_W-1:0]   rd_word;
  rsel_e              rsel;
  ptr_t               ptr_sel;
  logic               wrap_sel;

  // sum and divide
  logic [SUM_W-1:0]   acc_q;
  logic [SMP_W-1:0]   quo_q;
  logic [REC_W-1:0]   recip;
  logic [PROD_W-1:0]  prod;
  logic [CNT_W-1:0]   span;

  // result
  logic [SMP_W-1:0]   res_q;
  logic               out_vld_q;
  kind_e              out_kind_q;
  logic [SMP_W-1:0]   out_val_q;
  kind_e              kind;

  // Ring that the current item reads from.
  always_comb begin
    rsel = RSEL_NONE;
    unique case (act_q)
      ACT_PUSH: rsel = RSEL_SEC;
      ACT_MIN:  rsel = RSEL_SEC;
      ACT_QTR:  rsel = RSEL_MIN;
      ACT_READ: begin
        if (lvl_q == LVL_SEC) begin
          rsel = RSEL_SEC;
        end else if (lvl_q == LVL_MIN) begin
          rsel = RSEL_MIN;
        end else if (lvl_q == LVL_QTR) begin
          rsel = RSEL_QTR;
        end
      end
      default: rsel = RSEL_NONE;
    endcase
  end

  always_comb begin
    unique case (rsel)
      RSEL_SEC: begin
        ptr_sel  = sec_ptr_q;
        wrap_sel = sec_wrap_q;
        rd_word  = rd_sec_q;
      end
      RSEL_MIN: begin
        ptr_sel  = min_ptr_q;
        wrap_sel = min_wrap_q;
        rd_word  = rd_min_q;
      end
      RSEL_QTR: begin
        ptr_sel  = qtr_ptr_q;
        wrap_sel = qtr_wrap_q;
        rd_word  = rd_qtr_q;
      end
      default: begin
        ptr_sel  = '0;
        wrap_sel = 1'b0;
        rd_word  = '0;
      end
    endcase
  end

  assign span  = (act_q == ACT_MIN) ? CNT_W'(MIN_CNT) : CNT_W'(QTR_CNT);
  assign recip = (act_q == ACT_MIN) ? REC_W'(MIN_RECIP) : REC_W'(QTR_RECIP);
  // truncating mean by reciprocal multiply, exact over the whole sum range
  assign prod  = PROD_W'(acc_q) * PROD_W'(recip);

  always_comb begin
    unique case (act_q)
      ACT_MIN: kind = KIND_MIN;
      ACT_QTR: kind = KIND_QTR;
      default: kind = KIND_READ;
    endcase
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= act_e'(in_act_i);
      smp_q <= in_sample_i;
      lvl_q <= in_level_i;
      off_q <= {1'b0, in_age_i} + OFF_W'(1);
    end else if (cmd_i.off_sub) begin
      off_q <= off_q - OFF_W'(RING_DEPTH);
    end
  end

  // pointers; writes always go in slot order from zero, so wrap flag plus
  // pointer tell which slots hold data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_ptr_q  <= '0;
      min_ptr_q  <= '0;
      qtr_ptr_q  <= '0;
      sec_wrap_q <= 1'b0;
      min_wrap_q <= 1'b0;
      qtr_wrap_q <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        sec_ptr_q <= ring_next(sec_ptr_q);
        if (sec_ptr_q == PTR_W'(RING_DEPTH - 1)) sec_wrap_q <= 1'b1;
      end
      if (cmd_i.avg_wr && act_q == ACT_MIN) begin
        min_ptr_q <= ring_next(min_ptr_q);
        if (min_ptr_q == PTR_W'(RING_DEPTH - 1)) min_wrap_q <= 1'b1;
      end
      if (cmd_i.avg_wr && act_q == ACT_QTR) begin
        qtr_ptr_q <= ring_next(qtr_ptr_q);
        if (qtr_ptr_q == PTR_W'(RING_DEPTH - 1)) qtr_wrap_q <= 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) sec_mem[sec_ptr_q] <= smp_q;
    if (cmd_i.rd_en) rd_sec_q <= sec_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_wr && act_q == ACT_MIN) min_mem[min_ptr_q] <= quo_q;
    if (cmd_i.rd_en) rd_min_q <= min_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_wr && act_q == ACT_QTR) qtr_mem[qtr_ptr_q] <= quo_q;
    if (cmd_i.rd_en) rd_qtr_q <= qtr_mem[addr_q];
  end

  // read address walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_init) begin
      addr_q <= ring_back(ptr_sel, PTR_W'(1));
    end else if (cmd_i.raddr) begin
      addr_q <= ring_back(ptr_sel, PTR_W'(off_q));
    end else if (cmd_i.sum_step) begin
      addr_q <= ring_back(addr_q, PTR_W'(1));
    end
    if (cmd_i.rd_en) rd_ok_q <= wrap_sel || (addr_q < ptr_sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.sum_init) begin
        cnt_q <= span;
      end else if (cmd_i.sum_step) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // accumulate, then a registered reciprocal divide
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_init) begin
      acc_q <= '0;
    end else if (rd_vld_q) begin
      acc_q <= acc_q + SUM_W'(rd_ok_q ? rd_word : '0);
    end
    if (cmd_i.div_init) begin
      quo_q <= prod[RECIP_SH +: SMP_W];
    end
    if (cmd_i.avg_wr) begin
      res_q <= quo_q;
    end else if (cmd_i.res_rd) begin
      res_q <= rd_ok_q ? rd_word : '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= kind;
      out_val_q  <= res_q;
    end
  end

  assign sts_o.cnt_last = (cnt_q == CNT_W'(1));
  assign sts_o.off_big  = (32'(off_q) >= RING_DEPTH);
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_val_q;

endmodule

`default_nettype wire

[hdl/mrha_ctrl.sv]
`default_nettype none
`include "multi_rate_history_averager_assert.svh"

module mrha_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [mrha_pkg::ACT_W-1:0] in_act_i,
  output logic                       in_ready_o,
  input  mrha_pkg::sts_t             sts_i,
  output mrha_pkg::cmd_t             cmd_o
);
  import mrha_pkg::*;

  ctl_state_e state_q, state_d;
  logic       accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (act_e'(in_act_i))
            ACT_PUSH: state_d = S_PUSH;
            ACT_MIN:  state_d = S_SINIT;
            ACT_QTR:  state_d = S_SINIT;
            ACT_READ: state_d = S_MOD;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_PUSH:   state_d = S_IDLE;
      S_SINIT:  state_d = S_SUM;
      S_SUM:    if (sts_i.cnt_last) state_d = S_DRAIN;
      S_DRAIN:  state_d = S_DIVI;
      S_DIVI:   state_d = S_WRITE;
      S_WRITE:  state_d = S_OUT;
      S_MOD:    if (!sts_i.off_big) state_d = S_RADDR;
      S_RADDR:  state_d = S_RISSUE;
      S_RISSUE: state_d = S_RDATA;
      S_RDATA:  state_d = S_OUT;
      S_OUT:    if (sts_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_PUSH:  cmd_o.push = 1'b1;
      S_SINIT: cmd_o.sum_init = 1'b1;
      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        cmd_o.rd_en    = 1'b1;
      end
      S_DRAIN:  cmd_o = '0;
      S_DIVI:   cmd_o.div_init = 1'b1;
      S_WRITE:  cmd_o.avg_wr = 1'b1;
      S_MOD:    cmd_o.off_sub = sts_i.off_big;
      S_RADDR:  cmd_o.raddr = 1'b1;
      S_RISSUE: cmd_o.rd_en = 1'b1;
      S_RDATA:  cmd_o.res_rd = 1'b1;
      S_OUT:    cmd_o.out_load = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  `MRHA_ASSERT_IMM(a_out_no_overrun, cmd_o.out_load, sts_i.out_free)
  `MRHA_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `MRHA_ASSERT_NXT(a_div_to_write, state_q == S_DIVI, state_q == S_WRITE)
  `MRHA_ASSERT_NXT(a_sum_to_drain, state_q == S_SUM && sts_i.cnt_last, state_q == S_DRAIN)

endmodule

`default_nettype wire
